>>> rtl/vzc_pkg.sv
`timescale 1ns / 1ps
// Package for the varint / zigzag codec: request and result codes, group
// constants and the command/status structs between controller and datapath.
package vzc_pkg;

  // Request type codes carried in req_type.
  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // Result kind codes carried in out_kind.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  // One varint group is seven payload bits under a continuation flag.
  localparam int unsigned GROUP_BITS = 7;

  // Index of the final byte a decode may gather, per width.
  localparam logic [3:0] LAST_IDX_NARROW = 4'd4;
  localparam logic [3:0] LAST_IDX_WIDE   = 4'd9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_enc;  // Capture the mapped value of a new encode transaction.
    logic emit_enc;  // Move one encoded byte into the result register.
    logic dec_step;  // Fold the accepted byte into the decode accumulator.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic enc_last;  // The byte about to be emitted ends the varint.
    logic dec_done;  // The byte at the input completes a decoded value.
  } sts_t;

endpackage

>>> rtl/vzc_req_if.sv
`timescale 1ns / 1ps
// Request channel of the varint codec: valid/ready handshake with one item.
// Stand-alone; no package dependencies.
interface vzc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        wide;
  logic        zigzag;
  logic [63:0] value_in;
  logic [7:0]  byte_in;

  modport source (output valid, req_type, wide, zigzag, value_in, byte_in, input ready);
  modport sink   (input valid, req_type, wide, zigzag, value_in, byte_in, output ready);
endinterface

>>> rtl/vzc_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the varint codec: valid/ready handshake with one result.
// Stand-alone; no package dependencies.
interface vzc_rsp_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  byte_out;
  logic [63:0] value_out;
  logic        last_byte;

  modport source (output valid, out_kind, byte_out, value_out, last_byte, input ready);
  modport sink   (input valid, out_kind, byte_out, value_out, last_byte, output ready);
endinterface

>>> rtl/vzc_dp.sv
`timescale 1ns / 1ps
// Datapath of the varint codec: encode shift register, decode accumulator,
// zigzag mapping and the result register. Uses vzc_pkg.
module vzc_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vzc_pkg::cmd_t cmd_i,
  output vzc_pkg::sts_t sts_o,
  input  logic          wide_i,
  input  logic          zigzag_i,
  input  logic [63:0]   value_i,
  input  logic [7:0]    byte_i,
  output logic          out_kind_o,
  output logic [7:0]    byte_o,
  output logic [63:0]   value_o,
  output logic          last_o
);

  // Encode state.
  logic [63:0] enc_q, enc_d;
  logic [63:0] enc_map;
  logic [31:0] enc_v32;
  logic        enc_more;

  // Decode state.
  logic [63:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        wide_lat_q, wide_lat_d;
  logic        sgn_lat_q, sgn_lat_d;

  logic        wide_eff, sgn_eff;
  logic [6:0]  shamt;
  logic [63:0] grp64;
  logic [63:0] acc_new;
  logic [3:0]  last_idx;
  logic        dec_done;
  logic [31:0] dv32, dz32;
  logic [63:0] dec_res;

  // Result register.
  logic        kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [63:0] val_q, val_d;
  logic        last_q, last_d;

  // Zigzag map and width select for a value to encode.
  always_comb begin
    enc_v32 = value_i[31:0];
    if (wide_i) begin
      enc_map = zigzag_i ? ({value_i[62:0], 1'b0} ^ {64{value_i[63]}}) : value_i;
    end else begin
      enc_map = {32'd0, zigzag_i ? ({enc_v32[30:0], 1'b0} ^ {32{enc_v32[31]}}) : enc_v32};
    end
  end

  assign enc_more = |enc_q[63:vzc_pkg::GROUP_BITS];

  // The width and sign come from the first byte of a value, later bytes
  // follow the latched copy.
  always_comb begin
    wide_eff = (cnt_q == 4'd0) ? wide_i   : wide_lat_q;
    sgn_eff  = (cnt_q == 4'd0) ? zigzag_i : sgn_lat_q;
    shamt    = {cnt_q, 3'b000} - {3'b000, cnt_q};
    grp64    = {57'd0, byte_i[6:0]} << shamt;
    acc_new  = ((cnt_q == 4'd0) ? 64'd0 : acc_q) | grp64;
    if (!wide_eff) begin
      acc_new[63:32] = 32'd0;
    end
    last_idx = wide_eff ? vzc_pkg::LAST_IDX_WIDE : vzc_pkg::LAST_IDX_NARROW;
    dec_done = !byte_i[7] || (cnt_q == last_idx);

    dv32 = acc_new[31:0];
    dz32 = {1'b0, dv32[31:1]} ^ {32{dv32[0]}};
    if (wide_eff) begin
      dec_res = sgn_eff ? ({1'b0, acc_new[63:1]} ^ {64{acc_new[0]}}) : acc_new;
    end else begin
      dec_res = sgn_eff ? {{32{dz32[31]}}, dz32} : {32'd0, dv32};
    end
  end

  assign sts_o.enc_last = !enc_more;
  assign sts_o.dec_done = dec_done;

  always_comb begin
    enc_d      = enc_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    wide_lat_d = wide_lat_q;
    sgn_lat_d  = sgn_lat_q;
    kind_d     = kind_q;
    byte_d     = byte_q;
    val_d      = val_q;
    last_d     = last_q;

    if (cmd_i.load_enc) begin
      enc_d = enc_map;
    end
    if (cmd_i.emit_enc) begin
      enc_d  = enc_q >> vzc_pkg::GROUP_BITS;
      kind_d = vzc_pkg::KIND_BYTE;
      byte_d = {enc_more, enc_q[6:0]};
      val_d  = 64'd0;
      last_d = !enc_more;
    end
    if (cmd_i.dec_step) begin
      wide_lat_d = wide_eff;
      sgn_lat_d  = sgn_eff;
      if (dec_done) begin
        acc_d  = 64'd0;
        cnt_d  = 4'd0;
        kind_d = vzc_pkg::KIND_VALUE;
        byte_d = 8'd0;
        val_d  = dec_res;
        last_d = 1'b0;
      end else begin
        acc_d = acc_new;
        cnt_d = cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= 64'd0;
      cnt_q      <= 4'd0;
      wide_lat_q <= 1'b0;
      sgn_lat_q  <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      cnt_q      <= cnt_d;
      wide_lat_q <= wide_lat_d;
      sgn_lat_q  <= sgn_lat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    enc_q  <= enc_d;
    kind_q <= kind_d;
    byte_q <= byte_d;
    val_q  <= val_d;
    last_q <= last_d;
  end

  assign out_kind_o = kind_q;
  assign byte_o     = byte_q;
  assign value_o    = val_q;
  assign last_o     = last_q;

  // A partial decode never runs past the byte limit of its width.
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= vzc_pkg::LAST_IDX_WIDE) && (wide_lat_q || cnt_q <= vzc_pkg::LAST_IDX_NARROW))
    else $error("decode byte count beyond width limit");

  // A completed value restarts gathering at the first byte.
  a_cnt_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.dec_step && dec_done) |=> (cnt_q == 4'd0))
    else $error("decode count not cleared after a value");

endmodule

>>> rtl/vzc_ctrl.sv
`timescale 1ns / 1ps
// Controller of the varint codec: request handshake, encode byte sequencing
// and the result valid flag. Uses vzc_pkg.
module vzc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          req_type_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output vzc_pkg::cmd_t cmd_o,
  input  vzc_pkg::sts_t sts_i
);

  typedef enum logic {S_IDLE, S_ENC} state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  // The result slot can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == vzc_pkg::REQ_ENCODE) begin
            cmd_o.load_enc = 1'b1;
            state_d        = S_ENC;
          end else begin
            cmd_o.dec_step = 1'b1;
            if (sts_i.dec_done) begin
              out_valid_d = 1'b1;
            end
          end
        end
      end
      S_ENC: begin
        if (out_free) begin
          cmd_o.emit_enc = 1'b1;
          out_valid_d    = 1'b1;
          if (sts_i.enc_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted encode request always starts byte emission.
  a_enc_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == vzc_pkg::REQ_ENCODE) |=> (state_q == S_ENC))
    else $error("encode request did not start emission");

  // Emitting the final byte returns the controller to idle.
  a_enc_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_enc && sts_i.enc_last) |=> (state_q == S_IDLE))
    else $error("controller stayed in emission after the last byte");

  // A pending result is never dropped while the receiver stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("pending result dropped under stall");

  // Only one datapath command is issued at a time.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_enc, cmd_o.emit_enc, cmd_o.dec_step}))
    else $error("conflicting datapath commands");

endmodule

>>> rtl/varint_zigzag_codec.sv
`timescale 1ns / 1ps
// Varint codec with optional zigzag mapping in 32- or 64-bit width.
// Depends on vzc_pkg, vzc_req_if, vzc_rsp_if, vzc_ctrl and vzc_dp.
//
// Usage:
// Requests arrive on req_i and results leave on rsp_o; both use a valid/ready
// handshake and one transaction moves one item. An encode request
// (req_type = 0) takes value_in and yields one to ten byte results, low group
// first, the final one flagged by last_byte. A decode request (req_type = 1)
// takes one byte; a value result appears once a byte with a clear top bit
// arrives or the width's byte limit (5 or 10 bytes) is hit. Width and zigzag
// are taken from the first byte of each encoded value.
//
// Flow: a decode byte is accepted and its value, when complete, is valid in
// the cycle after, so bytes stream at one per cycle while the receiver takes
// every result. An encode request first loads the shift register and then
// emits its bytes from it one at a time through the single result register.
// Requests are not accepted while an encode is still emitting.
//
// Reset clears the partial decode and empties the result register. When the
// receiver stalls, the result is held and the request side stops accepting
// until the result register can be refilled.
module varint_zigzag_codec (
  input logic       clk_i,
  input logic       rst_ni,
  vzc_req_if.sink   req_i,
  vzc_rsp_if.source rsp_o
);

  // Controller and datapath talk only through these two structs.
  vzc_pkg::cmd_t cmd;
  vzc_pkg::sts_t sts;

  vzc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .req_type_i  (req_i.req_type),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath sees request fields directly; they only matter in the
  // cycle where the controller issues a load or decode command.
  vzc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .wide_i     (req_i.wide),
    .zigzag_i   (req_i.zigzag),
    .value_i    (req_i.value_in),
    .byte_i     (req_i.byte_in),
    .out_kind_o (rsp_o.out_kind),
    .byte_o     (rsp_o.byte_out),
    .value_o    (rsp_o.value_out),
    .last_o     (rsp_o.last_byte)
  );

endmodule

>>> tb/vzc_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the varint / zigzag codec: predicts every result from the
// accepted requests and compares each accepted result with the oldest one owed.
// Depends on vzc_pkg, vzc_req_if and vzc_rsp_if.
module vzc_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  vzc_req_if   req_mon_i,
  vzc_rsp_if   rsp_mon_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic        kind;
    logic [7:0]  byte_val;
    logic [63:0] value;
    logic        last;
  } codec_out_t;

  codec_out_t owed_q[$];

  // Partial decode: groups gathered so far, their count, and the width and
  // sign taken from the first byte of the value.
  logic [63:0] gathered_bits;
  logic [3:0]  gathered_count;
  logic        gather_wide;
  logic        gather_signed;

  function automatic void owe(logic kind, logic [7:0] b, logic [63:0] v, logic last);
    codec_out_t r;
    r = {kind, b, v, last};
    owed_q = {owed_q, r};
  endfunction

  function automatic void encode_varint(logic wide, logic zz, logic [63:0] raw);
    logic [63:0] mapped;
    logic [31:0] low;
    low = raw[31:0];
    if (wide) begin
      mapped = zz ? ((raw << 1) ^ {64{raw[63]}}) : raw;
    end else begin
      mapped = {32'd0, zz ? ((low << 1) ^ {32{low[31]}}) : low};
    end
    while (mapped >= 64'h80) begin
      owe(vzc_pkg::KIND_BYTE, {1'b1, mapped[6:0]}, 64'd0, 1'b0);
      mapped = mapped >> vzc_pkg::GROUP_BITS;
    end
    owe(vzc_pkg::KIND_BYTE, mapped[7:0], 64'd0, 1'b1);
  endfunction

  function automatic void decode_varint_byte(logic wide, logic zz, logic [7:0] b);
    logic [3:0]  limit;
    logic [63:0] res;
    logic [31:0] low;
    if (gathered_count == 4'd0) begin
      gather_wide   = wide;
      gather_signed = zz;
      gathered_bits = '0;
    end
    limit = (gather_wide ? vzc_pkg::LAST_IDX_WIDE : vzc_pkg::LAST_IDX_NARROW) + 4'd1;
    if (gathered_count >= limit) gathered_count = limit - 4'd1;
    gathered_bits = gathered_bits |
                    ({57'd0, b[6:0]} << (vzc_pkg::GROUP_BITS * gathered_count));
    if (!gather_wide) gathered_bits[63:32] = '0;
    gathered_count = gathered_count + 4'd1;
    // The value completes on a clear top bit or at the width's byte limit.
    if (b[7] && gathered_count < limit) return;
    low = gathered_bits[31:0];
    if (gather_wide) begin
      res = gather_signed ? ((gathered_bits >> 1) ^ {64{gathered_bits[0]}}) : gathered_bits;
    end else if (gather_signed) begin
      low = (low >> 1) ^ {32{low[0]}};
      res = {{32{low[31]}}, low};
    end else begin
      res = {32'd0, low};
    end
    gathered_bits  = '0;
    gathered_count = '0;
    owe(vzc_pkg::KIND_VALUE, 8'd0, res, 1'b0);
  endfunction

  function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    codec_out_t want;
    if (!rst_ni) begin
      owed_q.delete();
      gathered_bits  = '0;
      gathered_count = '0;
      gather_wide    = 1'b0;
      gather_signed  = 1'b0;
      fail_count_o   = 0;
    end else begin
      if (req_mon_i.valid && req_mon_i.ready) begin
        if (req_mon_i.req_type == vzc_pkg::REQ_DECODE) begin
          decode_varint_byte(req_mon_i.wide, req_mon_i.zigzag, req_mon_i.byte_in);
        end else begin
          encode_varint(req_mon_i.wide, req_mon_i.zigzag, req_mon_i.value_in);
        end
      end
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, %s %0d byte %h value %h last %0d",
                   $time, "actual kind", rsp_mon_i.out_kind, rsp_mon_i.byte_out,
                   rsp_mon_i.value_out, rsp_mon_i.last_byte);
          fail_count_o++;
        end else begin
          want = owed_q.pop_front();
          if (!field_ok("out_kind", want.kind, rsp_mon_i.out_kind)) fail_count_o++;
          if (!field_ok("byte_out", want.byte_val, rsp_mon_i.byte_out)) fail_count_o++;
          if (!field_ok("value_out", want.value, rsp_mon_i.value_out)) fail_count_o++;
          if (!field_ok("last_byte", want.last, rsp_mon_i.last_byte)) fail_count_o++;
        end
      end
    end
    pending_o = owed_q.size();
  end

endmodule

>>> tb/varint_zigzag_codec_test.sv
`timescale 1ns / 1ps
// Top of the varint / zigzag codec testbench: clock, reset, stimulus, flow
// control on the result side and the verdict. Depends on vzc_pkg, the two
// channel interfaces, the codec itself and vzc_result_checker.
module varint_zigzag_codec_test;

  // Generous bound: even with 80 percent stalls on every result of every
  // ten-byte encode, the run needs only a small fraction of this.
  localparam int CYCLE_LIMIT     = 400_000;
  // Random items per idling phase; with the directed part, about 110 items.
  localparam int PHASE_ITEMS     = 21;
  // Cycles to keep watching after the last result.
  localparam int SETTLE_CYCLES   = 16;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  vzc_req_if req_if ();
  vzc_rsp_if rsp_if ();

  int fail_count;
  int pending;
  int items_sent = 0;
  int cycles     = 0;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int idle_pct  = 0;
  int stall_pct = 0;

  varint_zigzag_codec DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  vzc_result_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon_i    (req_if),
    .rsp_mon_i    (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The receiver decides afresh on every edge whether it takes a result.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("varint_zigzag_codec_test failed");
    $finish;
  end

  // Offers one request and returns at the edge where the transaction takes
  // place. Valid stays high on return so that back-to-back requests need no
  // gap; a random idle stretch first lowers it.
  task automatic send_req(logic kind, logic wide, logic zz, logic [63:0] value,
                          logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.wide     <= wide;
    req_if.zigzag   <= zz;
    req_if.value_in <= value;
    req_if.byte_in  <= b;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Stops offering requests until every predicted result has come back. The
  // first edge lets the checker record the transaction that just took place.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Encode values spread over all magnitudes, so every byte count from one to
  // ten comes up, plus small negatives and the signed extremes.
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: pick_value = v;
      1: pick_value = v >> $urandom_range(63);
      2: pick_value = ~(v >> $urandom_range(63, 40));
      default: begin
        case ($urandom_range(3))
          0: pick_value = 64'h8000_0000_0000_0000;
          1: pick_value = 64'h7FFF_FFFF_FFFF_FFFF;
          2: pick_value = {v[63:32], 32'h8000_0000};
          default: pick_value = {v[63:32], 32'h7FFF_FFFF};
        endcase
      end
    endcase
  endfunction

  // One well-formed encoded value fed byte by byte: continuation bits set on
  // all but the final byte, or on every byte so that the byte limit closes
  // it. Later bytes carry random width and zigzag flags, which the codec must
  // ignore, and now and then an encode request slips in mid-value.
  task automatic send_decode_seq();
    logic       w;
    logic       z;
    int         n;
    int         limit;
    bit         over;
    logic [7:0] b;
    w = 1'($urandom);
    z = 1'($urandom);
    limit = w ? 10 : 5;
    n = $urandom_range(limit, 1);
    over = (n == limit) && ($urandom_range(1) == 1);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(9) == 0) begin
        send_req(vzc_pkg::REQ_ENCODE, 1'($urandom), 1'($urandom), pick_value(),
                 8'($urandom));
      end
      b = 8'($urandom);
      b[7] = (i < n - 1) || over;
      send_req(vzc_pkg::REQ_DECODE, (i == 0) ? w : logic'($urandom),
               (i == 0) ? z : logic'($urandom), {$urandom, $urandom}, b);
    end
  endtask

  initial begin
    int sel;
    req_if.valid    <= 1'b0;
    req_if.req_type <= vzc_pkg::REQ_ENCODE;
    req_if.wide     <= 1'b0;
    req_if.zigzag   <= 1'b0;
    req_if.value_in <= '0;
    req_if.byte_in  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with no idling on either side.
    // Encode extremes: zero, a full 32-bit value with junk in the upper half,
    // a full 64-bit value, the first two-byte value, and the most negative
    // signed values, which zigzag maps to all ones, and a 64-bit minus one.
    send_req(vzc_pkg::REQ_ENCODE, 1'b0, 1'b0, 64'd0, 8'hFF);
    send_req(vzc_pkg::REQ_ENCODE, 1'b0, 1'b0, 64'hDEAD_BEEF_FFFF_FFFF, 8'h00);
    send_req(vzc_pkg::REQ_ENCODE, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h55);
    send_req(vzc_pkg::REQ_ENCODE, 1'b1, 1'b0, 64'd128, 8'hAA);
    send_req(vzc_pkg::REQ_ENCODE, 1'b1, 1'b1, 64'h8000_0000_0000_0000, 8'h00);
    send_req(vzc_pkg::REQ_ENCODE, 1'b0, 1'b1, 64'hFFFF_FFFF_8000_0000, 8'h00);
    send_req(vzc_pkg::REQ_ENCODE, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
    // Decode of single-byte values: zero, and a negative signed 32-bit value
    // that must come out sign-extended.
    send_req(vzc_pkg::REQ_DECODE, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
    send_req(vzc_pkg::REQ_DECODE, 1'b0, 1'b1, 64'd0, 8'h7F);
    // A signed 32-bit value hitting the five-byte limit with the top bit
    // still set; the flags on later bytes contradict the first and are
    // ignored, and the excess bits of the fifth group are dropped.
    send_req(vzc_pkg::REQ_DECODE, 1'b0, 1'b1, 64'd0, 8'hFF);
    repeat (4) send_req(vzc_pkg::REQ_DECODE, 1'b1, 1'b0, 64'd0, 8'hFF);
    // A 64-bit value hitting the ten-byte limit, with an encode in the
    // middle that must leave the partial decode alone.
    send_req(vzc_pkg::REQ_DECODE, 1'b1, 1'b0, 64'd0, 8'hFF);
    repeat (4) send_req(vzc_pkg::REQ_DECODE, 1'b0, 1'b1, 64'd0, 8'hFF);
    send_req(vzc_pkg::REQ_ENCODE, 1'b0, 1'b0, 64'd300, 8'hFF);
    repeat (5) send_req(vzc_pkg::REQ_DECODE, 1'b0, 1'b0, 64'd0, 8'hFF);

    // Random part in four idling phases: none, a slow sender, a slow
    // receiver, and light idling on both sides. Mostly encode requests and
    // well-formed encoded values, with some stray bytes as noise.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 80 : (phase == 3) ? 13 : 0;
      stall_pct = (phase == 2) ? 80 : (phase == 3) ? 13 : 0;
      sel = items_sent + PHASE_ITEMS;
      while (items_sent < sel) begin
        case ($urandom_range(9))
          0: send_req(vzc_pkg::REQ_DECODE, 1'($urandom), 1'($urandom),
                      {$urandom, $urandom}, 8'($urandom));
          1, 2, 3, 4: send_decode_seq();
          default: send_req(vzc_pkg::REQ_ENCODE, 1'($urandom), 1'($urandom),
                            pick_value(), 8'($urandom));
        endcase
      end
      // Once mid-run the sender holds off until the codec has drained.
      if (phase == 1) wait_for_results();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("varint_zigzag_codec_test passed");
    end else begin
      $display("varint_zigzag_codec_test failed");
    end
    $finish;
  end

endmodule

>>> varint_zigzag_codec.f
rtl/vzc_pkg.sv
rtl/vzc_req_if.sv
rtl/vzc_rsp_if.sv
rtl/vzc_dp.sv
rtl/vzc_ctrl.sv
rtl/varint_zigzag_codec.sv
tb/vzc_result_checker.sv
tb/varint_zigzag_codec_test.sv
